### rtl/biquad_pkg.sv
package biquad_pkg;

   localparam int unsigned SampleWidth = 16;
   localparam int unsigned CoefWidth   = 16;
   localparam int unsigned CsrAddrWidth = 3;

   // product scaling: right shift applied to each rounded product
   localparam int unsigned ShiftB0 = 24;
   localparam int unsigned ShiftB1 = 23;
   localparam int unsigned ShiftB2 = 24;
   localparam int unsigned ShiftA1 = 14;
   localparam int unsigned ShiftA2 = 15;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic signed [CoefWidth-1:0]   coef_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_COEF_B0 = 3'd0,
      CSR_COEF_B1 = 3'd1,
      CSR_COEF_B2 = 3'd2,
      CSR_COEF_A1 = 3'd3,
      CSR_COEF_A2 = 3'd4
   } csr_addr_type;

   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type a1;
      coef_type a2;
   } coefs_type;

   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type y1;
      sample_type y2;
   } hist_type;

   localparam coef_type CoefB0Reset = 16'sh76B0;
   localparam coef_type CoefB1Reset = 16'sh76B0;
   localparam coef_type CoefB2Reset = 16'sh76B0;
   localparam coef_type CoefA1Reset = 16'sh74A7;
   localparam coef_type CoefA2Reset = 16'sh94D7;

   localparam sample_type XHistReset = 16'sh8001;  // -32767
   localparam sample_type YHistReset = 16'shC000;  // -16384

endpackage

### rtl/biquad_dp.sv
module biquad_dp (
   input  biquad_pkg::sample_type x,
   input  biquad_pkg::hist_type   hist,
   input  biquad_pkg::coefs_type  coefs,
   output biquad_pkg::sample_type y
);

   localparam int unsigned ProdWidth = 2 * biquad_pkg::SampleWidth;
   localparam int unsigned WideWidth = ProdWidth + 8;

   // round half up, arithmetic shift, keep low bits (sum wraps anyway)
   function automatic logic [biquad_pkg::SampleWidth-1:0] rnd_term(
      input biquad_pkg::coef_type   c,
      input biquad_pkg::sample_type d,
      input int unsigned            s
   );
      logic signed [ProdWidth-1:0] prod;
      logic signed [WideWidth-1:0] wide;
      logic signed [WideWidth-1:0] shifted;
      prod    = c * d;
      wide    = {{(WideWidth-ProdWidth){prod[ProdWidth-1]}}, prod};
      wide    = wide + (WideWidth'(1) <<< (s - 1));
      shifted = wide >>> s;
      return shifted[biquad_pkg::SampleWidth-1:0];
   endfunction

   logic [biquad_pkg::SampleWidth-1:0] t_b0, t_b1, t_b2, t_a1, t_a2;

   assign t_b0 = rnd_term(coefs.b0, x,       biquad_pkg::ShiftB0);
   assign t_b1 = rnd_term(coefs.b1, hist.x1, biquad_pkg::ShiftB1);
   assign t_b2 = rnd_term(coefs.b2, hist.x2, biquad_pkg::ShiftB2);
   assign t_a1 = rnd_term(coefs.a1, hist.y1, biquad_pkg::ShiftA1);
   assign t_a2 = rnd_term(coefs.a2, hist.y2, biquad_pkg::ShiftA2);

   assign y = biquad_pkg::sample_type'(t_b0 + t_b1 + t_b2 + t_a1 + t_a2);

endmodule

### rtl/biquad_iir_fixed_point_top.sv
// Direct form I biquad on signed 16-bit samples: each req transaction carries one input
// sample and yields exactly one rsp transaction with the filtered sample, in order. The
// block sustains one sample per clock while rsp_tready does not hold the output register:
// an input register feeds five parallel 16x16 multiplies, rounding and a wrapping 16-bit
// sum, all combinational, and the result lands in the output register while the x/y
// histories shift; that output register drives rsp_tvalid. This combinational
// multiply-and-sum closes the y feedback loop and sets the clock limit. Coefficients are
// written through csr_* (index 0..4: b0, b1, b2, a1, a2; other indexes are ignored) and
// take effect for samples computed afterward; write them only while the filter is idle.
// After reset the histories hold x = -32767, y = -16384.
module biquad_iir_fixed_point_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // input sample channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [biquad_pkg::SampleWidth-1:0]   req_tdata,   // [15:0] x_sample
   // filtered sample channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [biquad_pkg::SampleWidth-1:0]   rsp_tdata,   // [15:0] y_sample
   // coefficient write port
   input  logic                                 csr_we,
   input  logic [biquad_pkg::CsrAddrWidth-1:0]  csr_addr,
   input  logic [biquad_pkg::CoefWidth-1:0]     csr_wdata
);

   // coefficient registers
   biquad_pkg::coefs_type coefs_ff, coefs_in;

   // input stage
   logic                   s1_valid_ff, s1_valid_in;
   biquad_pkg::sample_type s1_data_ff, s1_data_in;

   // output stage
   logic                   s2_valid_ff, s2_valid_in;
   biquad_pkg::sample_type s2_data_ff, s2_data_in;

   // filter state
   biquad_pkg::hist_type   hist_ff, hist_in;

   biquad_pkg::sample_type y_new;
   logic                   s1_advance;
   logic                   req_take;

   // input stage moves on whenever the output register is free or being drained
   assign s1_advance = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = s2_data_ff;

   biquad_dp u_dp (
      .x     (s1_data_ff),
      .hist  (hist_ff),
      .coefs (coefs_ff),
      .y     (y_new)
   );

   // coefficient writes; only the low register indexes decode
   always_comb begin
      coefs_in = coefs_ff;
      if (csr_we) begin
         case (biquad_pkg::csr_addr_type'(csr_addr))
            biquad_pkg::CSR_COEF_B0: coefs_in.b0 = csr_wdata;
            biquad_pkg::CSR_COEF_B1: coefs_in.b1 = csr_wdata;
            biquad_pkg::CSR_COEF_B2: coefs_in.b2 = csr_wdata;
            biquad_pkg::CSR_COEF_A1: coefs_in.a1 = csr_wdata;
            biquad_pkg::CSR_COEF_A2: coefs_in.a2 = csr_wdata;
            default: coefs_in = coefs_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_tdata;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // result and history update together, so feedback sees y[n-1] next cycle
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_data_in  = s2_data_ff;
      hist_in     = hist_ff;
      if (s1_advance) begin
         s2_valid_in = 1'b1;
         s2_data_in  = y_new;
         hist_in.x2  = hist_ff.x1;
         hist_in.x1  = s1_data_ff;
         hist_in.y2  = hist_ff.y1;
         hist_in.y1  = y_new;
      end else if (rsp_tready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.b0 <= biquad_pkg::CoefB0Reset;
         coefs_ff.b1 <= biquad_pkg::CoefB1Reset;
         coefs_ff.b2 <= biquad_pkg::CoefB2Reset;
         coefs_ff.a1 <= biquad_pkg::CoefA1Reset;
         coefs_ff.a2 <= biquad_pkg::CoefA2Reset;
         hist_ff.x1  <= biquad_pkg::XHistReset;
         hist_ff.x2  <= biquad_pkg::XHistReset;
         hist_ff.y1  <= biquad_pkg::YHistReset;
         hist_ff.y2  <= biquad_pkg::YHistReset;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         coefs_ff    <= coefs_in;
         hist_ff     <= hist_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

`ifndef SYNTHESIS
   // a pending result is always the newest y history entry
   a_out_matches_hist: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_data_ff == hist_ff.y1))
      else $error("output register differs from y history");

   // an advancing sample becomes x[n-1]
   a_x_hist_shift: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (hist_ff.x1 == $past(s1_data_ff)))
      else $error("x history did not take advancing sample");

   // a blocked input stage keeps its sample
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("stalled input stage lost its sample");
`endif

endmodule
